// ===== hdl/irtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - shared definitions
// Frame bytes, byte positions, field widths and the result record.
// ----------------------------------------------------------------------------
package irtf_pkg;

	// field widths
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 10;
	localparam int WORD_W   = 16;
	localparam int OBJECT_W = 17;
	localparam int POS_W    = 4;

	// frame constants
	localparam logic [BYTE_W-1:0]   HDR_BYTE     = 8'h5A;
	localparam logic [BYTE_W-1:0]   TYPE_TEMP    = 8'h45;
	localparam logic [BYTE_W-1:0]   LEN_REQUIRED = 8'h04;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd168;

	// byte positions within a frame
	localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
	localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
	localparam logic [POS_W-1:0] POS_TYPE   = 4'd2;
	localparam logic [POS_W-1:0] POS_LEN    = 4'd3;
	localparam logic [POS_W-1:0] POS_OBJ_HI = 4'd4;
	localparam logic [POS_W-1:0] POS_OBJ_LO = 4'd5;
	localparam logic [POS_W-1:0] POS_AMB_HI = 4'd6;
	localparam logic [POS_W-1:0] POS_AMB_LO = 4'd7;
	localparam logic [POS_W-1:0] POS_CHECK  = 4'd8;

	// one finished result handed from the parser to the output register
	typedef struct packed {
		logic                valid;
		logic [OBJECT_W-1:0] object_temp_centi;
		logic [WORD_W-1:0]   ambient_temp_centi;
	} irtf_result_t;

endpackage

// ===== hdl/irtf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - channel interfaces
// Byte input channel and temperature result channel, valid/ready.
// ----------------------------------------------------------------------------
interface irtf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface irtf_temp_if;
	logic        valid;
	logic        ready;
	logic [16:0] object_temp_centi;
	logic [15:0] ambient_temp_centi;

	modport source (output valid, output object_temp_centi, output ambient_temp_centi,
		input ready);
	modport sink   (input valid, input object_temp_centi, input ambient_temp_centi,
		output ready);
endinterface

// ===== hdl/ir_temp_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - top level
// Parses 0x5A 0x5A framed sensor bytes and emits checked temperature readings.
// ----------------------------------------------------------------------------
// Usage:
//   rx    - byte channel, one received serial byte per request.
//   temp  - result channel: object temperature (word + offset) and ambient
//           temperature, both in hundredths of a degree. One request per good
//           type 0x45 frame; other types, bad lengths and bad checksums give
//           none.
//   cfg_we/cfg_wdata - writes the object offset; change it only while idle.
// Path: the checksum byte passes the input register, then its result is
//   loaded into the result register, which drives temp.valid.
// Throughput: one byte per cycle unless a result is held; the input register
//   feeds the parser, which updates position, checksum and words per byte.
// Reset: parser returns to hunting for a header, the offset goes to 168
//   (1.68 degrees), no result is pending.
// Stall: a pending result waits in the output register; bytes keep flowing
//   while it is taken, and rx.ready drops only while the result is held and
//   the next byte cannot be parsed.
// ----------------------------------------------------------------------------
module ir_temp_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	irtf_byte_if.sink                     rx,
	irtf_temp_if.source                   temp,
	input  logic                          cfg_we,
	input  logic [irtf_pkg::OFFSET_W-1:0] cfg_wdata
);
	import irtf_pkg::*;

	logic [OFFSET_W-1:0] offset_q;
	logic                slot_free;
	irtf_result_t        res;

	// offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	irtf_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.offset    (offset_q),
		.slot_free (slot_free),
		.res       (res)
	);

	irtf_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.slot_free (slot_free),
		.temp      (temp)
	);

endmodule

// ===== hdl/irtf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - frame parser
// Registers each incoming byte, then walks the frame one byte per cycle
// unless stalled, keeping a running checksum and the two temperature words.
// ----------------------------------------------------------------------------
module irtf_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	irtf_byte_if.sink                         rx,
	input  logic [irtf_pkg::OFFSET_W-1:0]     offset,
	input  logic                              slot_free,
	output irtf_pkg::irtf_result_t            res
);
	import irtf_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              type_ok_q, type_ok_d;
	logic [WORD_W-1:0] obj_q, obj_d;
	logic [WORD_W-1:0] amb_q, amb_d;
	logic              emit;

	// held byte moves on when the result slot can take whatever it produces
	assign advance  = valid_s1 && slot_free;
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// frame walk: next position, checksum and words
	always_comb begin
		pos_d     = pos_q;
		sum_d     = sum_q + byte_s1;
		type_ok_d = type_ok_q;
		obj_d     = obj_q;
		amb_d     = amb_q;
		case (pos_q)
			POS_HDR1: begin
				pos_d = (byte_s1 == HDR_BYTE) ? POS_TYPE : POS_HDR0;
			end
			POS_TYPE: begin
				type_ok_d = (byte_s1 == TYPE_TEMP);
				pos_d     = POS_LEN;
			end
			POS_LEN: begin
				pos_d = (byte_s1 == LEN_REQUIRED) ? POS_OBJ_HI : POS_HDR0;
			end
			POS_OBJ_HI, POS_OBJ_LO, POS_AMB_HI, POS_AMB_LO: begin
				pos_d = pos_q + 4'd1;
				if (pos_q == POS_OBJ_HI) obj_d[15:8] = byte_s1;
				if (pos_q == POS_OBJ_LO) obj_d[7:0]  = byte_s1;
				if (pos_q == POS_AMB_HI) amb_d[15:8] = byte_s1;
				if (pos_q == POS_AMB_LO) amb_d[7:0]  = byte_s1;
			end
			POS_CHECK: begin
				pos_d = POS_HDR0;
			end
			default: begin
				// first header byte; also recovers from any stray position
				sum_d = byte_s1;
				pos_d = (byte_s1 == HDR_BYTE) ? POS_HDR1 : POS_HDR0;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR0;
		end else if (advance) begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sum_q     <= sum_d;
			type_ok_q <= type_ok_d;
			obj_q     <= obj_d;
			amb_q     <= amb_d;
		end
	end

	// checksum byte of a temperature frame that adds up
	assign emit = advance && (pos_q == POS_CHECK) && type_ok_q && (sum_q == byte_s1);

	always_comb begin
		res.valid              = emit;
		res.object_temp_centi  = {1'b0, obj_q} + {{(OBJECT_W-OFFSET_W){1'b0}}, offset};
		res.ambient_temp_centi = amb_q;
	end

endmodule

// ===== hdl/irtf_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module irtf_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  irtf_pkg::irtf_result_t res,
	output logic                   slot_free,
	irtf_temp_if.source            temp
);
	import irtf_pkg::*;

	logic                valid_q;
	logic [OBJECT_W-1:0] obj_q;
	logic [WORD_W-1:0]   amb_q;

	// free when empty or being drained this cycle
	assign slot_free = !valid_q || temp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.valid) begin
			valid_q <= 1'b1;
		end else if (temp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			obj_q <= res.object_temp_centi;
			amb_q <= res.ambient_temp_centi;
		end
	end

	assign temp.valid              = valid_q;
	assign temp.object_temp_centi  = obj_q;
	assign temp.ambient_temp_centi = amb_q;

endmodule

// ===== hdl/irtf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR thermometer frame receiver - port checker
// Watches the channel ports for stall and latency behavior.
// ----------------------------------------------------------------------------
module irtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] out_object,
	input logic [15:0] out_ambient
);

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_object) && $stable(out_ambient))
		else $error("stalled result changed or dropped");

	// input only stalls while a result is held back
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a new result follows an accepted byte through the input and result registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a checksum byte two cycles before");

endmodule

bind ir_temp_frame_receiver irtf_checker u_irtf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (rx.valid),
	.in_ready    (rx.ready),
	.out_valid   (temp.valid),
	.out_ready   (temp.ready),
	.out_object  (temp.object_temp_centi),
	.out_ambient (temp.ambient_temp_centi)
);
